>>> rtl/cbcs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the circle/box collision slide block.
package cbcs_pkg;

  localparam int COORD_BITS    = 24;
  localparam int RADSQ_BITS    = 48;
  localparam int COUNT_BITS    = 7;
  localparam int INDEX_BITS    = 6;
  localparam int DEF_MAX_BOXES = 64;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_MOVE  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    REG_RADIUS_SQUARED = 3'd0,
    REG_BOXES_IN_USE   = 3'd1,
    REG_BOUND_MIN_X    = 3'd2,
    REG_BOUND_MAX_X    = 3'd3,
    REG_BOUND_MIN_Z    = 3'd4,
    REG_BOUND_MAX_Z    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XPASS,
    ST_ZPASS,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t                 func;
    logic [INDEX_BITS-1:0] box_index;
    coord_t                box_min_x;
    coord_t                box_max_x;
    coord_t                box_min_z;
    coord_t                box_max_z;
    coord_t                pos_x;
    coord_t                pos_z;
    coord_t                delta_x;
    coord_t                delta_z;
  } cmd_t;

  typedef struct packed {
    coord_t new_x;
    coord_t new_z;
    logic   x_blocked;
    logic   z_blocked;
  } res_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t hi_x;
    coord_t lo_z;
    coord_t hi_z;
  } box_t;

  // status of the distance pipeline, seen by the sequencer
  typedef struct packed {
    logic busy;
    logic hit_vld;
    logic hit;
  } dist_stat_t;

  // below lo gives lo, else above hi gives hi (also for inverted edges)
  function automatic coord_t clamp3(coord_t v, coord_t lo, coord_t hi);
    coord_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic [COORD_BITS:0] s;
    coord_t r;
    s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    if (s[COORD_BITS] != s[COORD_BITS-1]) begin
      r = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
    end else begin
      r = s[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cbcs_dist.sv
`timescale 1ns / 1ps
// Pipelined circle-to-box distance test, shared by every box of both passes.
module cbcs_dist (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                box_vld,
  input  cbcs_pkg::box_t                      box,
  input  cbcs_pkg::coord_t                    px,
  input  cbcs_pkg::coord_t                    pz,
  input  logic [cbcs_pkg::RADSQ_BITS-1:0]     radius_squared,
  output cbcs_pkg::dist_stat_t                stat
);
  import cbcs_pkg::*;

  localparam int SQ_BITS = 2 * COORD_BITS;

  coord_t                     cx;
  coord_t                     cz;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dz;
  logic signed [COORD_BITS:0] ndx;
  logic signed [COORD_BITS:0] ndz;
  logic [COORD_BITS-1:0]      mag_x_next;
  logic [COORD_BITS-1:0]      mag_z_next;
  logic [COORD_BITS-1:0]      mag_x;
  logic [COORD_BITS-1:0]      mag_z;
  logic [SQ_BITS-1:0]         sq_x;
  logic [SQ_BITS-1:0]         sq_z;
  logic [SQ_BITS:0]           dist_sum;
  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic                       hit;

  // stage 1: closest point on the box, then |offset| per axis (fits 24 bits)
  always_comb begin
    cx  = clamp3(px, box.lo_x, box.hi_x);
    cz  = clamp3(pz, box.lo_z, box.hi_z);
    dx  = {px[COORD_BITS-1], px} - {cx[COORD_BITS-1], cx};
    dz  = {pz[COORD_BITS-1], pz} - {cz[COORD_BITS-1], cz};
    ndx = -dx;
    ndz = -dz;
    mag_x_next = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    mag_z_next = dz[COORD_BITS] ? ndz[COORD_BITS-1:0] : dz[COORD_BITS-1:0];
  end

  assign dist_sum = {1'b0, sq_x} + {1'b0, sq_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= box_vld;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    mag_x <= mag_x_next;
    mag_z <= mag_z_next;
    sq_x  <= mag_x * mag_x;
    sq_z  <= mag_z * mag_z;
    hit   <= (dist_sum < (SQ_BITS+1)'(radius_squared));
  end

  assign stat.busy    = v1 | v2 | v3;
  assign stat.hit_vld = v3;
  assign stat.hit     = hit;

endmodule

>>> rtl/circle_box_collision_slide.sv
`timescale 1ns / 1ps
// Top level: box table, move sequencer, config registers and result register.
//
//  channel  direction  payload           handshake
//  cmd      in         cbcs_pkg::cmd_t   cmd_valid / cmd_stall
//  res      out        cbcs_pkg::res_t   res_valid / res_stall
//  apb      in/out     64-bit registers  psel, penable, pwrite, pready
//
// A move runs two passes over the table, one box per cycle through the table
// read and the 3-stage distance pipeline, over n = min(boxes_in_use, MAX_BOXES)
// boxes; cmd_stall is held for the whole move, and the result is valid at the
// edge that ends the stall. A finished result waits in the output register; the
// next move can start meanwhile but cannot finish until res is taken. Reset sets
// the registers; the table is not cleared.
module circle_box_collision_slide #(
  parameter int MAX_BOXES = cbcs_pkg::DEF_MAX_BOXES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  cbcs_pkg::cmd_t                       cmd,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output cbcs_pkg::res_t                       res,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cbcs_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [cbcs_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [cbcs_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import cbcs_pkg::*;

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int NW    = ($clog2(MAX_BOXES + 1) > COUNT_BITS) ?
                         $clog2(MAX_BOXES + 1) : COUNT_BITS;

  // config registers
  logic [RADSQ_BITS-1:0] radius_squared;
  logic [COUNT_BITS-1:0] boxes_in_use;
  coord_t                bound_min_x;
  coord_t                bound_max_x;
  coord_t                bound_min_z;
  coord_t                bound_max_z;
  logic                  cfg_we;
  reg_idx_t              reg_idx;

  // sequencer
  state_t                state;
  state_t                state_next;
  logic [NW-1:0]         cnt;
  logic [NW-1:0]         n_lim;
  logic                  issue;
  logic                  pass_done;
  logic                  accept;
  logic                  res_load;
  logic                  acc;
  logic                  xb;
  logic                  zb;

  // move datapath
  coord_t                pos_x;
  coord_t                pos_z;
  coord_t                tgt_x;
  coord_t                tgt_z;
  coord_t                px;
  coord_t                pz;

  // table
  box_t                  mem [MAX_BOXES];
  box_t                  rd_box;
  box_t                  wr_box;
  logic                  rd_vld;
  logic                  mem_we;
  logic [NW-1:0]         wr_full;
  dist_stat_t            stat;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:3]);

  always_comb begin
    unique case (reg_idx)
      REG_RADIUS_SQUARED: prdata = CFG_DATA_BITS'(radius_squared);
      REG_BOXES_IN_USE:   prdata = CFG_DATA_BITS'(boxes_in_use);
      REG_BOUND_MIN_X:    prdata = CFG_DATA_BITS'($unsigned(bound_min_x));
      REG_BOUND_MAX_X:    prdata = CFG_DATA_BITS'($unsigned(bound_max_x));
      REG_BOUND_MIN_Z:    prdata = CFG_DATA_BITS'($unsigned(bound_min_z));
      REG_BOUND_MAX_Z:    prdata = CFG_DATA_BITS'($unsigned(bound_max_z));
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared <= RADSQ_BITS'(65536);
      boxes_in_use   <= '0;
      bound_min_x    <= COORD_MIN;
      bound_max_x    <= COORD_MAX;
      bound_min_z    <= COORD_MIN;
      bound_max_z    <= COORD_MAX;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_RADIUS_SQUARED: radius_squared <= pwdata[RADSQ_BITS-1:0];
        REG_BOXES_IN_USE:   boxes_in_use   <= pwdata[COUNT_BITS-1:0];
        REG_BOUND_MIN_X:    bound_min_x    <= pwdata[COORD_BITS-1:0];
        REG_BOUND_MAX_X:    bound_max_x    <= pwdata[COORD_BITS-1:0];
        REG_BOUND_MIN_Z:    bound_min_z    <= pwdata[COORD_BITS-1:0];
        REG_BOUND_MAX_Z:    bound_max_z    <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign n_lim     = (NW'(boxes_in_use) > NW'(MAX_BOXES)) ? NW'(MAX_BOXES)
                                                          : NW'(boxes_in_use);

  always_comb begin
    issue      = ((state == ST_XPASS) || (state == ST_ZPASS)) && (cnt < n_lim);
    pass_done  = (cnt >= n_lim) && !rd_vld && !stat.busy;
    res_load   = (state == ST_DONE) && (!res_valid || !res_stall);
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && (cmd.func == FUNC_MOVE)) state_next = ST_XPASS;
      ST_XPASS: if (pass_done) state_next = ST_ZPASS;
      ST_ZPASS: if (pass_done) state_next = ST_DONE;
      ST_DONE:  if (res_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      acc       <= 1'b0;
      rd_vld    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if ((state == ST_IDLE) || pass_done) begin
        cnt <= '0;
        acc <= 1'b0;
      end else begin
        if (issue) begin
          cnt <= cnt + NW'(1);
        end
        if (stat.hit_vld && stat.hit) begin
          acc <= 1'b1;
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // ---------------- move datapath ----------------
  // x pass tests (target x, old z); z pass tests (resolved x, target z)
  assign px = (state == ST_ZPASS) ? pos_x : tgt_x;
  assign pz = (state == ST_ZPASS) ? tgt_z : pos_z;

  always_ff @(posedge clk) begin
    if (accept && (cmd.func == FUNC_MOVE)) begin
      pos_x <= cmd.pos_x;
      pos_z <= cmd.pos_z;
      tgt_x <= sat_add(cmd.pos_x, cmd.delta_x);
      tgt_z <= sat_add(cmd.pos_z, cmd.delta_z);
    end
    if ((state == ST_XPASS) && pass_done) begin
      xb <= acc;
      if (!acc) begin
        pos_x <= tgt_x;
      end
    end
    if ((state == ST_ZPASS) && pass_done) begin
      zb <= acc;
      if (!acc) begin
        pos_z <= tgt_z;
      end
    end
    if (res_load) begin
      res.new_x     <= clamp3(pos_x, bound_min_x, bound_max_x);
      res.new_z     <= clamp3(pos_z, bound_min_z, bound_max_z);
      res.x_blocked <= xb;
      res.z_blocked <= zb;
    end
  end

  // ---------------- box table ----------------
  assign wr_full     = NW'(cmd.box_index);
  assign mem_we      = accept && (cmd.func == FUNC_WRITE) && (wr_full < NW'(MAX_BOXES));
  assign wr_box.lo_x = cmd.box_min_x;
  assign wr_box.hi_x = cmd.box_max_x;
  assign wr_box.lo_z = cmd.box_min_z;
  assign wr_box.hi_z = cmd.box_max_z;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_full[IDX_W-1:0]] <= wr_box;
    end
    if (issue) begin
      rd_box <= mem[cnt[IDX_W-1:0]];
    end
  end

  cbcs_dist u_dist (
    .clk            (clk),
    .rst            (rst),
    .box_vld        (rd_vld),
    .box            (rd_box),
    .px             (px),
    .pz             (pz),
    .radius_squared (radius_squared),
    .stat           (stat)
  );

endmodule

>>> rtl/cbcs_props.sv
`timescale 1ns / 1ps
// Port-level checks for the circle/box slide block, bound to the top level.
module cbcs_props (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input cbcs_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_stall,
  input cbcs_pkg::res_t res
);
  import cbcs_pkg::*;

  // a held result stays put until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // a box write finishes in its own cycle
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.func == FUNC_WRITE) |=> !cmd_stall)
    else $error("box write left the block busy");

  // a move keeps the block busy at least for the next cycle
  a_move_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.func == FUNC_MOVE) |=> cmd_stall)
    else $error("move accepted without going busy");

  // a new result only appears at the end of a move
  a_res_from_move: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_stall))
    else $error("result appeared outside a move");

endmodule

bind circle_box_collision_slide cbcs_props u_props (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for circle_box_collision_slide: box table, x/z slide moves, bounds.
module testbench;
  import cbcs_pkg::*;

  localparam int     TABLE_SLOTS   = DEF_MAX_BOXES;
  localparam longint CMIN          = -(longint'(1) << (COORD_BITS - 1));
  localparam longint CMAX          = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam int     TARGET_ITEMS  = 1000;
  localparam int     PHASE_ITEMS   = 60;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     LONG_HOLD     = 1500;
  localparam int     CYCLE_LIMIT   = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  circle_box_collision_slide dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow of the box table and the registers
  longint      box_lo_x[TABLE_SLOTS];
  longint      box_hi_x[TABLE_SLOTS];
  longint      box_lo_z[TABLE_SLOTS];
  longint      box_hi_z[TABLE_SLOTS];
  logic [47:0] cfg_radius_sq = 48'd65536;
  int          cfg_box_count = 0;
  longint      cfg_min_x = CMIN;
  longint      cfg_max_x = CMAX;
  longint      cfg_min_z = CMIN;
  longint      cfg_max_z = CMAX;

  cmd_t pending_cmds[$];
  res_t expected_moves[$];

  int  sender_idle_pct = 0;
  int  receiver_idle_pct = 0;
  int  sender_gap = 0;
  int  receiver_hold = 0;
  bit  long_hold_done = 0;
  int  results_received = 0;
  int  error_count = 0;
  int  x_hits = 0;
  int  z_hits = 0;
  int  cycle_count = 0;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] dist_sq(longint d);
    longint m;
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic bit table_blocks(longint x, longint z);
    int     n;
    bit     hit;
    longint cx;
    longint cz;
    n = (cfg_box_count > TABLE_SLOTS) ? TABLE_SLOTS : cfg_box_count;
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      cx = clamp_to(x, box_lo_x[i], box_hi_x[i]);
      cz = clamp_to(z, box_lo_z[i], box_hi_z[i]);
      if (dist_sq(x - cx) + dist_sq(z - cz) < {16'd0, cfg_radius_sq}) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic res_t resolve_move(cmd_t c);
    longint x;
    longint z;
    longint tx;
    longint tz;
    res_t   r;
    x = $signed(c.pos_x);
    z = $signed(c.pos_z);
    tx = clamp_to(x + longint'($signed(c.delta_x)), CMIN, CMAX);
    tz = clamp_to(z + longint'($signed(c.delta_z)), CMIN, CMAX);
    r.x_blocked = table_blocks(tx, z);
    if (!r.x_blocked) x = tx;
    r.z_blocked = table_blocks(x, tz);
    if (!r.z_blocked) z = tz;
    x = clamp_to(x, cfg_min_x, cfg_max_x);
    z = clamp_to(z, cfg_min_z, cfg_max_z);
    r.new_x = x[COORD_BITS-1:0];
    r.new_z = z[COORD_BITS-1:0];
    return r;
  endfunction

  function automatic void track_cmd(cmd_t c);
    if (c.func == FUNC_WRITE) begin
      box_lo_x[c.box_index] = $signed(c.box_min_x);
      box_hi_x[c.box_index] = $signed(c.box_max_x);
      box_lo_z[c.box_index] = $signed(c.box_min_z);
      box_hi_z[c.box_index] = $signed(c.box_max_z);
    end else begin
      expected_moves.push_back(resolve_move(c));
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic coord_t near(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.func      = func_t'($urandom_range(0, 1));
    c.box_index = INDEX_BITS'($urandom);
    c.box_min_x = coord_t'($urandom);
    c.box_max_x = coord_t'($urandom);
    c.box_min_z = coord_t'($urandom);
    c.box_max_z = coord_t'($urandom);
    c.pos_x     = coord_t'($urandom);
    c.pos_z     = coord_t'($urandom);
    c.delta_x   = coord_t'($urandom);
    c.delta_z   = coord_t'($urandom);
    return c;
  endfunction

  function automatic cmd_t box_cmd(int slot, coord_t lx, coord_t hx, coord_t lz, coord_t hz);
    cmd_t c;
    c = noise_cmd();
    c.func = FUNC_WRITE;
    c.box_index = INDEX_BITS'(slot);
    c.box_min_x = lx;
    c.box_max_x = hx;
    c.box_min_z = lz;
    c.box_max_z = hz;
    return c;
  endfunction

  function automatic cmd_t move_cmd(coord_t px, coord_t pz, coord_t dx, coord_t dz);
    cmd_t c;
    c = noise_cmd();
    c.func = FUNC_MOVE;
    c.pos_x = px;
    c.pos_z = pz;
    c.delta_x = dx;
    c.delta_z = dz;
    return c;
  endfunction

  // boxes clustered in a small area so moves actually run into them
  function automatic cmd_t random_box(int slot);
    coord_t lx;
    coord_t lz;
    coord_t hx;
    coord_t hz;
    lx = near(6000);
    lz = near(6000);
    hx = lx + coord_t'($urandom_range(0, 2000));
    hz = lz + coord_t'($urandom_range(0, 2000));
    if ($urandom_range(0, 7) == 0) return box_cmd(slot, hx, lx, hz, lz);
    return box_cmd(slot, lx, hx, lz, hz);
  endfunction

  function automatic cmd_t random_move();
    case ($urandom_range(0, 9))
      0:       return move_cmd(near(7000), near(7000), '0, '0);
      1:       return move_cmd(near(7000), near(7000), near(8000), near(8000));
      default: return move_cmd(near(7000), near(7000), near(900), near(900));
    endcase
  endfunction

  function automatic void random_bounds(output longint lo, output longint hi);
    case ($urandom_range(0, 5))
      0: begin
        lo = -3000 - longint'($urandom_range(0, 6000));
        hi = lo + longint'($urandom_range(0, 9000));
      end
      1: begin lo = $urandom_range(0, 3000); hi = -longint'($urandom_range(0, 3000)); end
      2: begin lo = $signed(coord_t'($urandom)); hi = $signed(coord_t'($urandom)); end
      default: begin lo = CMIN; hi = CMAX; end
    endcase
  endfunction

  // registers are written only with the block idle
  task automatic set_register(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
    case (idx)
      REG_RADIUS_SQUARED: cfg_radius_sq = value[47:0];
      REG_BOXES_IN_USE:   cfg_box_count = int'(value[COUNT_BITS-1:0]);
      REG_BOUND_MIN_X:    cfg_min_x = $signed(value[COORD_BITS-1:0]);
      REG_BOUND_MAX_X:    cfg_max_x = $signed(value[COORD_BITS-1:0]);
      REG_BOUND_MIN_Z:    cfg_min_z = $signed(value[COORD_BITS-1:0]);
      REG_BOUND_MAX_Z:    cfg_max_z = $signed(value[COORD_BITS-1:0]);
      default: ;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_all(logic [47:0] rsq, int count, longint mnx, longint mxx,
                         longint mnz, longint mxz);
    set_register(REG_RADIUS_SQUARED, {16'd0, rsq});
    set_register(REG_BOXES_IN_USE, 64'(count));
    set_register(REG_BOUND_MIN_X, 64'(mnx));
    set_register(REG_BOUND_MAX_X, 64'(mxx));
    set_register(REG_BOUND_MIN_Z, 64'(mnz));
    set_register(REG_BOUND_MAX_Z, 64'(mxz));
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_valid) @(posedge clk);
    while (expected_moves.size() != 0) @(posedge clk);
    // a box write leaves no result behind, give the block time to finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- sender ----------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid  <= 1'b0;
      sender_gap <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) track_cmd(cmd);
      if (!cmd_valid || !cmd_stall) begin
        if (sender_gap != 0) begin
          cmd_valid  <= 1'b0;
          sender_gap <= sender_gap - 1;
        end else if (pending_cmds.size() != 0) begin
          if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            cmd_valid  <= 1'b0;
            sender_gap <= $urandom_range(0, 11);
          end else begin
            cmd       <= pending_cmds.pop_front();
            cmd_valid <= 1'b1;
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (rst) begin
      res_stall     <= 1'b0;
      receiver_hold <= 0;
    end else if (receiver_hold != 0) begin
      res_stall     <= 1'b1;
      receiver_hold <= receiver_hold - 1;
    end else if (!long_hold_done && results_received >= 40) begin
      // long hold-off: the block fills up and must stall its input
      res_stall      <= 1'b1;
      receiver_hold  <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (receiver_idle_pct != 0 && $urandom_range(0, 99) < receiver_idle_pct) begin
      res_stall     <= 1'b1;
      receiver_hold <= $urandom_range(0, 11);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // ---------------- result checker ----------------
  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_moves.size() == 0) begin
        $error("result with no move outstanding: new_x %0d new_z %0d",
               $signed(res.new_x), $signed(res.new_z));
        error_count++;
      end else begin
        want = expected_moves.pop_front();
        check_field("new_x", $signed(want.new_x), $signed(res.new_x));
        check_field("new_z", $signed(want.new_z), $signed(res.new_z));
        check_field("x_blocked", want.x_blocked, res.x_blocked);
        check_field("z_blocked", want.z_blocked, res.z_blocked);
        x_hits += want.x_blocked;
        z_hits += want.z_blocked;
      end
      results_received <= results_received + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d moves outstanding", cycle_count,
               expected_moves.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    int     pushed;
    int     phase;
    int     count;
    int     r;
    int     pick;
    longint mnx;
    longint mxx;
    longint mnz;
    longint mxz;
    logic [47:0] rsq;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct   <= 10;
    receiver_idle_pct <= 10;

    // saturating sums with no boxes in use, then a few hand-placed boxes
    set_all(48'd65536, 0, CMIN, CMAX, CMIN, CMAX);
    pending_cmds.push_back(move_cmd(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    pending_cmds.push_back(move_cmd(COORD_MIN, COORD_MAX, -24'sd1, 24'sd1));
    pending_cmds.push_back(move_cmd('0, '0, '0, '0));
    pending_cmds.push_back(box_cmd(0, 24'sd0, 24'sd1024, 24'sd0, 24'sd1024));
    pending_cmds.push_back(box_cmd(1, 24'sd3000, 24'sd2000, -24'sd500, -24'sd1500));
    pending_cmds.push_back(box_cmd(2, COORD_MIN, COORD_MAX, 24'sd7000, 24'sd7100));
    drain();

    set_register(REG_BOXES_IN_USE, 64'd3);
    pending_cmds.push_back(move_cmd(-24'sd600, 24'sd512, 24'sd400, 24'sd10));
    // lands exactly one radius away: not a hit
    pending_cmds.push_back(move_cmd(-24'sd400, 24'sd512, 24'sd144, 24'sd0));
    // already overlapping with zero delta: both axes blocked
    pending_cmds.push_back(move_cmd(24'sd512, 24'sd512, 24'sd0, 24'sd0));
    pending_cmds.push_back(move_cmd(24'sd512, -24'sd600, 24'sd5, 24'sd400));
    pending_cmds.push_back(move_cmd(24'sd2900, -24'sd520, 24'sd50, -24'sd5));
    pending_cmds.push_back(move_cmd(24'sd0, 24'sd6600, 24'sd0, 24'sd200));
    drain();

    // zero radius, inverted x world bounds, ordinary z world bounds
    set_all(48'd0, 3, 1000, -1000, -100, 100);
    pending_cmds.push_back(move_cmd(24'sd512, 24'sd512, 24'sd0, 24'sd0));
    pending_cmds.push_back(move_cmd(-24'sd5000, 24'sd50, -24'sd10, 24'sd0));
    pending_cmds.push_back(move_cmd(24'sd2000, -24'sd300, 24'sd0, 24'sd0));
    drain();

    // largest radius, bounds pinned to the extremes
    set_all(48'hFFFF_FFFF_FFFF, 3, CMAX, CMAX, CMIN, CMIN);
    pending_cmds.push_back(move_cmd(24'sd100, 24'sd100, 24'sd1, 24'sd1));
    pending_cmds.push_back(move_cmd(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    drain();

    pushed = 17;
    phase = 0;
    while (pushed < TARGET_ITEMS) begin
      r = $urandom_range(0, 1024);
      rsq = 48'(r * r);
      count = $urandom_range(0, 12);
      random_bounds(mnx, mxx);
      random_bounds(mnz, mxz);
      case ($urandom_range(0, 9))
        0: rsq = 48'd0;
        1: rsq = 48'({$urandom, $urandom});
        default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) count = TABLE_SLOTS;
      else if (pick == 1) count = $urandom_range(TABLE_SLOTS + 1, 127);
      // first phase fills the whole table before any wide count is used
      if (phase == 0) count = 3;
      if (phase == 1) count = TABLE_SLOTS;
      if (phase == 2) count = 127;
      set_all(rsq, count, mnx, mxx, mnz, mxz);

      if (pushed + PHASE_ITEMS >= TARGET_ITEMS) begin
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
      end else begin
        pick = $urandom_range(0, 3);
        sender_idle_pct   <= (pick == 0) ? 0 : (pick == 1) ? 40 : 10;
        pick = $urandom_range(0, 3);
        receiver_idle_pct <= (pick == 0) ? 0 : (pick == 1) ? 40 : 10;
      end

      if (phase == 0) begin
        for (int s = 0; s < TABLE_SLOTS; s++) begin
          pending_cmds.push_back(random_box(s));
          pushed++;
          if ($urandom_range(0, 2) == 0) begin
            pending_cmds.push_back(random_move());
            pushed++;
          end
        end
      end else begin
        for (int k = 0; k < PHASE_ITEMS; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) pending_cmds.push_back(noise_cmd());
          else if (pick < 30) pending_cmds.push_back(random_box($urandom_range(0, 63)));
          else pending_cmds.push_back(random_move());
          pushed++;
        end
      end
      drain();
      phase++;
    end

    $display("%0d items over %0d random configurations plus directed cases", pushed, phase);
    $display("%0d moves checked, %0d x and %0d z moves blocked", results_received,
             x_hits, z_hits);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
